### hdl/sha1_message_digest_assert.svh
// Assertion macros shared by the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define SHA1_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1 check failed");

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define SHA1_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1 check failed");

`endif

### hdl/sha1_pkg.sv
// Package with the SHA-1 constants, round function and controller/datapath types.
package sha1_pkg;

  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int NUM_WORDS   = 5;
  localparam int WORD_IDX_W  = 3;
  localparam int BLOCK_WORDS = 16;
  localparam int POS_W       = 6;
  localparam int CNT_W       = 61;
  localparam int LEN_W       = 64;
  localparam int ROUNDS      = 80;
  localparam int ROUND_W     = 7;
  localparam int PHASE_LEN   = 20;

  // Byte position at which the length field starts.
  localparam logic [POS_W-1:0] LEN_POS  = 6'd56;
  localparam logic [POS_W-1:0] LAST_POS = 6'd63;
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  localparam logic [WORD_W-1:0] K_TAB [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [WORD_W-1:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Source of a byte pushed into the block buffer.
  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  push;
    src_t                  push_sel;
    logic                  count;
    logic                  latch_len;
    logic                  round_start;
    logic                  round_en;
    logic [1:0]            round_phase;
    logic                  finalize;
    logic                  reinit;
    logic [WORD_IDX_W-1:0] word_sel;
  } sha1_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [POS_W-1:0] pos;
  } sha1_status_t;

  // Round function selected by the 20-round phase.
  function automatic logic [WORD_W-1:0] sha1_f(input logic [1:0] phase,
                                               input logic [WORD_W-1:0] b,
                                               input logic [WORD_W-1:0] c,
                                               input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] res;
    case (phase)
      2'd0:    res = (b & c) | (~b & d);
      2'd2:    res = (b & c) | (b & d) | (c & d);
      default: res = b ^ c ^ d;
    endcase
    return res;
  endfunction

endpackage

### hdl/sha1_if.sv
// Handshake interfaces for the message byte channel and the digest word channel.
interface sha1_in_if;
  import sha1_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic              end_of_message;

  modport source(output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if;
  import sha1_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [WORD_W-1:0]     digest_word;
  logic [WORD_IDX_W-1:0] word_index;
  logic                  last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

### hdl/sha1_datapath.sv
// Datapath: byte packing, 16-word schedule window, round unit and chaining words.
module sha1_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sha1_pkg::BYTE_W-1:0]   data_byte,
  input  sha1_pkg::sha1_cmd_t           cmd,
  output sha1_pkg::sha1_status_t        status,
  output logic [sha1_pkg::WORD_W-1:0]   digest_word
);
  import sha1_pkg::*;

  logic [WORD_W-1:0]        win_r [BLOCK_WORDS];
  logic [3*BYTE_W-1:0]      acc_r;
  logic [LEN_W-1:0]         len_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [POS_W-1:0]         pos_r;
  logic [WORD_W-1:0]        chain_r [NUM_WORDS];
  logic [WORD_W-1:0]        a_r, b_r, c_r, d_r, e_r;

  logic [BYTE_W-1:0]        byte_in;
  logic [WORD_W-1:0]        w_new;
  logic [WORD_W-1:0]        w_mix;
  logic [WORD_W-1:0]        tmp;

  // Byte chosen for the buffer: message, pad marker, zero fill or length.
  always_comb begin
    case (cmd.push_sel)
      SRC_MSG:   byte_in = data_byte;
      SRC_PAD80: byte_in = PAD_BYTE;
      SRC_LEN:   byte_in = len_r[LEN_W-1 -: BYTE_W];
      default:   byte_in = '0;
    endcase
  end

  // Message schedule: the window holds w[t..t+15], w[t+16] is shifted in.
  assign w_mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

  // One compression round.
  assign tmp = {a_r[WORD_W-6:0], a_r[WORD_W-1 -: 5]}
             + sha1_f(cmd.round_phase, b_r, c_r, d_r)
             + e_r + K_TAB[cmd.round_phase] + win_r[0];

  // Byte packing and schedule window shifts.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      acc_r <= {acc_r[2*BYTE_W-1:0], byte_in};
      if (pos_r[1:0] == 2'd3) begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[BLOCK_WORDS-1] <= {acc_r, byte_in};
      end
    end else if (cmd.round_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[BLOCK_WORDS-1] <= w_new;
    end
  end

  // Length field, shifted out most significant byte first.
  always_ff @(posedge clk) begin
    if (cmd.latch_len) begin
      len_r <= {cnt_r, 3'b000};
    end else if (cmd.push && (cmd.push_sel == SRC_LEN)) begin
      len_r <= {len_r[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
  end

  // Working variables a..e.
  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round_en) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[WORD_W-1:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // Chaining words, byte count and buffer position.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reinit) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        chain_r[i] <= H_INIT[i];
      end
      cnt_r <= '0;
      pos_r <= '0;
    end else begin
      if (cmd.finalize) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (cmd.push) begin
        pos_r <= pos_r + 1'b1;
      end
      if (cmd.push && cmd.count) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign status.pos  = pos_r;
  assign digest_word = chain_r[cmd.word_sel];

endmodule

### hdl/sha1_controller.sv
// Controller: sequences message bytes, padding, compression rounds and digest output.
module sha1_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               byte_present,
  input  logic                               end_of_message,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [sha1_pkg::WORD_IDX_W-1:0]    word_index,
  output logic                               last_word,
  input  sha1_pkg::sha1_status_t             status,
  output sha1_pkg::sha1_cmd_t                cmd
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  state_t                state_r, state_nxt;
  state_t                ret_r, ret_nxt;
  logic [ROUND_W-1:0]    round_r, round_nxt;
  logic                  first_pad_r, first_pad_nxt;
  logic [WORD_IDX_W-1:0] word_r, word_nxt;
  logic                  accept;
  logic                  at_last_pos;

  assign accept      = in_valid && in_ready;
  assign at_last_pos = (status.pos == LAST_POS);

  // Next state and commands.
  always_comb begin
    state_nxt       = state_r;
    ret_nxt         = ret_r;
    round_nxt       = round_r;
    first_pad_nxt   = first_pad_r;
    word_nxt        = word_r;
    cmd.push        = 1'b0;
    cmd.push_sel    = SRC_MSG;
    cmd.count       = 1'b0;
    cmd.latch_len   = 1'b0;
    cmd.round_start = 1'b0;
    cmd.round_en    = 1'b0;
    cmd.finalize    = 1'b0;
    cmd.reinit      = 1'b0;
    cmd.word_sel    = word_r;
    if (round_r < ROUND_W'(PHASE_LEN)) begin
      cmd.round_phase = 2'd0;
    end else if (round_r < ROUND_W'(2 * PHASE_LEN)) begin
      cmd.round_phase = 2'd1;
    end else if (round_r < ROUND_W'(3 * PHASE_LEN)) begin
      cmd.round_phase = 2'd2;
    end else begin
      cmd.round_phase = 2'd3;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          first_pad_nxt = 1'b1;
          if (byte_present) begin
            cmd.push  = 1'b1;
            cmd.count = 1'b1;
          end
          if (byte_present && at_last_pos) begin
            cmd.round_start = 1'b1;
            round_nxt       = '0;
            ret_nxt         = end_of_message ? ST_PAD : ST_IDLE;
            state_nxt       = ST_COMP;
          end else if (end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 1'b1;
        if (round_r == ROUND_W'(ROUNDS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finalize = 1'b1;
        word_nxt     = '0;
        state_nxt    = ret_r;
      end
      ST_PAD: begin
        if (first_pad_r || (status.pos != LEN_POS)) begin
          cmd.push      = 1'b1;
          cmd.push_sel  = first_pad_r ? SRC_PAD80 : SRC_ZERO;
          cmd.latch_len = first_pad_r;
          first_pad_nxt = 1'b0;
          if (at_last_pos) begin
            cmd.round_start = 1'b1;
            round_nxt       = '0;
            ret_nxt         = ST_PAD;
            state_nxt       = ST_COMP;
          end
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.push     = 1'b1;
        cmd.push_sel = SRC_LEN;
        if (at_last_pos) begin
          cmd.round_start = 1'b1;
          round_nxt       = '0;
          ret_nxt         = ST_OUT;
          state_nxt       = ST_COMP;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          word_nxt = word_r + 1'b1;
          if (last_word) begin
            cmd.reinit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      round_r     <= '0;
      first_pad_r <= 1'b0;
      word_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      round_r     <= round_nxt;
      first_pad_r <= first_pad_nxt;
      word_r      <= word_nxt;
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = (state_r == ST_OUT);
  assign word_index = word_r;
  assign last_word  = (word_r == WORD_IDX_W'(NUM_WORDS - 1));

endmodule

### hdl/sha1_message_digest.sv
// SHA-1 digest engine: a completed 64-byte block holds off input through its rounds and finalize step.
// Compression runs on the single round unit, one round per cycle.
// An end item adds padding bytes, one or two compressions and five output words.
// Output words leave one per cycle while out_if.ready is high; no input is taken meanwhile.
// Reset (rst_n low, synchronous) loads the initial chaining words and clears counters and control.
// Block buffer contents are not reset; every byte is written or padded before use.
`include "sha1_message_digest_assert.svh"

module sha1_message_digest (
  input  logic       clk,
  input  logic       rst_n,
  sha1_in_if.sink    in_if,
  sha1_out_if.source out_if
);
  import sha1_pkg::*;

  sha1_cmd_t    cmd;
  sha1_status_t status;

  sha1_controller u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .byte_present   (in_if.byte_present),
    .end_of_message (in_if.end_of_message),
    .in_ready       (in_if.ready),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .word_index     (out_if.word_index),
    .last_word      (out_if.last_word),
    .status         (status),
    .cmd            (cmd)
  );

  sha1_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_if.data_byte),
    .cmd         (cmd),
    .status      (status),
    .digest_word (out_if.digest_word)
  );

  // The block never takes an item while digest words are offered.
  `SHA1_ASSERT_NOW(a_no_overlap, out_if.valid, !in_if.ready)
  // Once the last word is taken, the block is ready for a new message.
  `SHA1_ASSERT_NEXT(a_ready_after_last, out_if.valid && out_if.ready && out_if.last_word, in_if.ready)
  // A digest is only offered with the buffer back at a block boundary.
  `SHA1_ASSERT_NOW(a_out_aligned, out_if.valid, status.pos == '0)
  // Rounds and buffer pushes never happen in the same cycle.
  `SHA1_ASSERT_NOW(a_push_round_excl, cmd.round_en, !cmd.push)

endmodule

### dv/sha1_digest_checker.sv
`timescale 1ns / 1ps
// Digest checker: watches both channels, predicts SHA-1 digest words and compares them.
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  sha1_in_if          in_mon,
  sha1_out_if         out_mon,
  output int unsigned error_count,
  output int unsigned words_due
);
  import sha1_pkg::*;

  // Standard SHA-1 starting chain and round constants.
  localparam logic [WORD_W-1:0] CHAIN_IV [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [WORD_W-1:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };
  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h80;

  typedef struct packed {
    logic [WORD_W-1:0]     digest;
    logic [WORD_IDX_W-1:0] index;
    logic                  last;
  } digest_word_t;

  logic [WORD_W-1:0] msg_block [BLOCK_WORDS];
  logic [WORD_W-1:0] chain [NUM_WORDS];
  logic [CNT_W-1:0]  msg_bytes;
  digest_word_t      digest_q [$];
  int unsigned       errs = 0;

  function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  // Run the 80 SHA-1 rounds over the current block and fold them into the chain.
  task automatic compress_block();
    logic [WORD_W-1:0] sched [ROUNDS];
    logic [WORD_W-1:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < BLOCK_WORDS; i++) sched[i] = msg_block[i];
    for (int i = BLOCK_WORDS; i < ROUNDS; i++)
      sched[i] = rol(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < ROUNDS; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
      end else if (i >= 40 && i < 60) begin
        f = (b & c) | (b & d) | (c & d);
      end else begin
        f = b ^ c ^ d;
      end
      k = ROUND_K[i / 20];
      t = rol(a, 5) + f + e + k + sched[i];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endtask

  // Bytes fill each word most significant lane first.
  task automatic place_byte(input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] val);
    msg_block[pos[POS_W-1:2]][(3 - pos[1:0]) * 8 +: 8] = val;
  endtask

  task automatic restart_message();
    foreach (chain[i]) chain[i] = CHAIN_IV[i];
    msg_bytes = '0;
  endtask

  // Take one input item; an end item queues the five digest words.
  task automatic absorb_item(input logic [BYTE_W-1:0] val, input logic present,
                             input logic eom);
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] bit_len;
    if (present) begin
      pos = msg_bytes[POS_W-1:0];
      place_byte(pos, val);
      msg_bytes = msg_bytes + 1'b1;
      if (pos == 6'd63) compress_block();
    end
    if (eom) begin
      pos = msg_bytes[POS_W-1:0];
      place_byte(pos, MARKER_BYTE);
      for (int i = pos + 1; i < 64; i++) place_byte(POS_W'(i), 8'h00);
      // No room left for the length field: close this block and open an empty one.
      if (pos >= 6'd56) begin
        compress_block();
        foreach (msg_block[i]) msg_block[i] = '0;
      end
      bit_len = {msg_bytes, 3'b000};
      msg_block[14] = bit_len[63:32];
      msg_block[15] = bit_len[31:0];
      compress_block();
      for (int i = 0; i < NUM_WORDS; i++)
        digest_q.push_back('{chain[i], WORD_IDX_W'(i), i == NUM_WORDS - 1});
      restart_message();
    end
  endtask

  // Compare accepted digest words first, then fold in the accepted input item.
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst_n) begin
      restart_message();
      foreach (msg_block[i]) msg_block[i] = '0;
      digest_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word: digest_word %h word_index %0d last_word %0b",
                 out_mon.digest_word, out_mon.word_index, out_mon.last_word);
          errs++;
        end else begin
          want = digest_q.pop_front();
          if (out_mon.digest_word !== want.digest) begin
            $error("digest_word mismatch: expected %h, actual %h",
                   want.digest, out_mon.digest_word);
            errs++;
          end
          if (out_mon.word_index !== want.index) begin
            $error("word_index mismatch: expected %0d, actual %0d",
                   want.index, out_mon.word_index);
            errs++;
          end
          if (out_mon.last_word !== want.last) begin
            $error("last_word mismatch: expected %0b, actual %0b",
                   want.last, out_mon.last_word);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb_item(in_mon.data_byte, in_mon.byte_present, in_mon.end_of_message);
    end
    error_count <= errs;
    words_due <= digest_q.size();
  end

endmodule

### dv/sha1_message_digest_tb.sv
`timescale 1ns / 1ps
// Testbench top for the SHA-1 digest block: clock, reset, message stimulus and verdict.
module sha1_message_digest_tb;
  import sha1_pkg::*;

  localparam int unsigned ITEM_TARGET    = 460;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  // Worst end item: padding, two compressions and five words out.
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned EDGE_LEN [5]   = '{55, 56, 63, 64, 119};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic hold_req = 1'b0;

  int unsigned error_count;
  int unsigned words_due;
  int unsigned tx_idle_pct = 38;
  int unsigned rx_idle_pct = 80;
  int unsigned items_sent = 0;

  sha1_in_if  in_if();
  sha1_out_if out_if();

  sha1_message_digest dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  sha1_digest_checker digest_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .error_count (error_count),
    .words_due   (words_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one item, with random gaps before it, and hold it until ready is seen high.
  task automatic send_item(input logic [BYTE_W-1:0] val, input logic present,
                           input logic eom);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.data_byte <= BYTE_W'($urandom_range(255));
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= val;
    in_if.byte_present <= present;
    in_if.end_of_message <= eom;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (present || eom) items_sent++;
  endtask

  // Random bytes, sprinkled with idle items; the end rides on the last byte or stands alone.
  task automatic send_message(input int unsigned len);
    logic bare_end;
    bare_end = (len == 0) || ($urandom_range(1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
      send_item(BYTE_W'($urandom_range(255)), 1'b1, !bare_end && i == len - 1);
    end
    if (bare_end) send_item(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Drop valid and wait until every queued digest word has left the block.
  task automatic wait_digests_out();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  // Mostly short messages, some at the padding boundaries, a few of medium length.
  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) return $urandom_range(12);
    if (sel < 8) return EDGE_LEN[$urandom_range(4)];
    return $urandom_range(80);
  endfunction

  // Receiver: random ready, with one long hold-off on request.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Sender: reset, directed messages, then random messages in three idle phases.
  initial begin
    bit hold_asked;
    hold_asked = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.byte_present = 1'b0;
    in_if.end_of_message = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty message closed by a bare end marker.
    send_item(8'hA5, 1'b0, 1'b1);
    // Idle item between messages.
    send_item(8'h3C, 1'b0, 1'b0);
    // One zero byte carrying the end flag.
    send_item(8'h00, 1'b1, 1'b1);
    // One all-ones byte, then a bare end marker.
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // The classic three-letter message.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Idle item inside a message.
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b1);
    wait_digests_out();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent < ITEM_TARGET / 3) begin
        tx_idle_pct = 38;
        rx_idle_pct = 80;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
        tx_idle_pct = 80;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Back-pressure the output while the sender keeps pushing a short message.
      if (!hold_asked && items_sent >= 2 * ITEM_TARGET / 3) begin
        hold_asked = 1'b1;
        hold_req <= 1'b1;
        send_message(4);
      end
      send_message(pick_length());
      if ($urandom_range(7) == 0) wait_digests_out();
    end

    wait_digests_out();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && words_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing digest words.
  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
